// File: src/schema_event_mask_classifier_assert.svh
`ifndef SCHEMA_EVENT_MASK_CLASSIFIER_ASSERT_SVH
`define SCHEMA_EVENT_MASK_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define SEMC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define SEMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/semc_pkg.sv
package semc_pkg;

	localparam int SCHEMA_SLOTS     = 255;
	localparam int EXPRESSION_LIMIT = 31;

	localparam int KIND_W   = 2;
	localparam int REQ_W    = 5;
	localparam int REJ_W    = 8;
	localparam int SNUM_W   = 8;
	localparam int EXPR_W   = 5;
	localparam int STATUS_W = 3;
	localparam int FLAG_W   = 32;

	localparam int IDX_W = (SCHEMA_SLOTS > 1) ? $clog2(SCHEMA_SLOTS) : 1;
	localparam int CNT_W = $clog2(SCHEMA_SLOTS + 1);

	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [REQ_W-1:0]    req_t;
	typedef logic [REJ_W-1:0]    rej_t;
	typedef logic [SNUM_W-1:0]   snum_t;
	typedef logic [EXPR_W-1:0]   expr_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [FLAG_W-1:0]   flag_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	localparam kind_t KIND_DEFINE = 2'd0;
	localparam kind_t KIND_BEGIN  = 2'd1;
	localparam kind_t KIND_EVENT  = 2'd2;
	localparam kind_t KIND_DECIDE = 2'd3;

	localparam status_t ST_DEFINED  = 3'd0;
	localparam status_t ST_FULL     = 3'd1;
	localparam status_t ST_TOO_MANY = 3'd2;
	localparam status_t ST_FOUND    = 3'd3;
	localparam status_t ST_NONE     = 3'd4;

	typedef enum logic [1:0] {
		ALU_PASS,
		ALU_ARM,
		ALU_SET_REJECT,
		ALU_CLEAR_BIT
	} alu_op_t;

	// Access to the schema store: one address per cycle for both tables.
	typedef struct packed {
		idx_t  addr;
		logic  req_we;
		req_t  req_wdata;
		logic  flag_we;
		flag_t flag_wdata;
	} store_req_t;

endpackage

// File: src/semc_in_if.sv
interface semc_in_if import semc_pkg::*;;
	logic  valid;
	logic  ready;
	kind_t kind;
	req_t  required_count;
	rej_t  reject_count;
	logic  is_reject;
	snum_t schema_number;
	expr_t expression_number;

	modport source (
		output valid, kind, required_count, reject_count, is_reject,
		       schema_number, expression_number,
		input  ready
	);
	modport sink (
		input  valid, kind, required_count, reject_count, is_reject,
		       schema_number, expression_number,
		output ready
	);
endinterface

// File: src/semc_out_if.sv
interface semc_out_if import semc_pkg::*;;
	logic    valid;
	logic    ready;
	status_t status;
	snum_t   schema_index;

	modport source (
		output valid, status, schema_index,
		input  ready
	);
	modport sink (
		input  valid, status, schema_index,
		output ready
	);
endinterface

// File: src/semc_flag_alu.sv
module semc_flag_alu import semc_pkg::*; (
	input  alu_op_t op,
	input  flag_t   word,
	input  req_t    count,
	input  expr_t   bit_sel,
	output flag_t   result,
	output logic    zero
);

	flag_t mask_w;

	// Pending mask for count select expressions, built in bits 0..count-1 and moved to bits 1..count on arm.
	assign mask_w = (flag_t'(1) << count) - flag_t'(1);
	assign zero   = (word == '0);

	always_comb begin
		unique case (op)
			ALU_ARM:        result = {mask_w[FLAG_W-2:0], 1'b0};
			ALU_SET_REJECT: result = word | flag_t'(1);
			ALU_CLEAR_BIT:  result = word & ~(flag_t'(1) << bit_sel);
			default:        result = word;
		endcase
	end

endmodule

// File: src/semc_store.sv
module semc_store import semc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  store_req_t req,
	output req_t       req_rdata,
	output flag_t      flag_rdata
);

	req_t  req_mem  [SCHEMA_SLOTS];
	flag_t flag_mem [SCHEMA_SLOTS];
	logic [SCHEMA_SLOTS-1:0] armed_q;
	req_t  req_rd_q;
	flag_t flag_rd_q;
	logic  armed_rd_q;

	// Storage and registered reads; no reset on payload.
	always_ff @(posedge clk) begin
		if (req.req_we) begin
			req_mem[req.addr] <= req.req_wdata;
		end
		if (req.flag_we) begin
			flag_mem[req.addr] <= req.flag_wdata;
		end
		req_rd_q  <= req_mem[req.addr];
		flag_rd_q <= flag_mem[req.addr];
	end

	// A flag word never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q    <= '0;
			armed_rd_q <= 1'b0;
		end else begin
			if (req.flag_we) begin
				armed_q[req.addr] <= 1'b1;
			end
			armed_rd_q <= armed_q[req.addr];
		end
	end

	assign req_rdata  = req_rd_q;
	assign flag_rdata = armed_rd_q ? flag_rd_q : '0;

endmodule

// File: src/schema_event_mask_classifier.sv
// Schema event mask classifier. Items arrive on item and are taken one at a
// time; item.ready is low while an item is in work. A define goes to the emit
// state, which loads the result register; an event passes a read and a write
// state; a begin a read and a write state per defined schema; a decide a read
// and a check state per schema up to a match or the last, then the emit state.
// Walks are serial: the schema store has a single port (one address per cycle
// for both tables) and one flag unit arms, updates and tests every flag word in
// turn. Results leave through a one-entry output register, so a new item is
// taken while a result still waits for its transfer. Flag words start at zero
// after reset by way of one armed bit per slot, so no clearing pass is needed.
module schema_event_mask_classifier import semc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	semc_in_if.sink   item,
	semc_out_if.source result
);

`include "schema_event_mask_classifier_assert.svh"

	typedef enum logic [2:0] {
		S_IDLE,
		S_BEGIN_RD,
		S_BEGIN_WR,
		S_EVT_RD,
		S_EVT_WR,
		S_DEC_RD,
		S_DEC_CHK,
		S_EMIT
	} state_t;

	state_t     state_q;
	cnt_t       count_q;
	idx_t       idx_q;
	logic       is_reject_q;
	expr_t      expr_q;
	status_t    emit_status_q;
	snum_t      emit_index_q;
	logic       out_valid_q;
	status_t    out_status_q;
	snum_t      out_index_q;

	store_req_t store_req;
	req_t       req_rdata;
	flag_t      flag_rdata;
	alu_op_t    alu_op;
	flag_t      alu_word;
	flag_t      alu_result;
	logic       alu_zero;

	logic       accept;
	logic       def_full;
	logic       def_too_many;
	logic       evt_ignored;
	snum_t      snum_m1;
	cnt_t       idx_next;
	logic       idx_last;
	logic       out_free;

	assign accept   = item.valid && item.ready;
	assign out_free = !out_valid_q || result.ready;

	assign def_full     = (count_q >= cnt_t'(SCHEMA_SLOTS));
	assign def_too_many = (item.required_count > req_t'(EXPRESSION_LIMIT)) ||
	                      (item.reject_count > rej_t'(EXPRESSION_LIMIT));
	assign snum_m1      = item.schema_number - snum_t'(1);
	assign evt_ignored  = (item.schema_number == '0) ||
	                      (item.schema_number > snum_t'(count_q));
	assign idx_next     = cnt_t'(idx_q) + cnt_t'(1);
	assign idx_last     = (idx_next == count_q);

	// Drive the store and the flag unit from the sequencer state.
	always_comb begin
		store_req            = '0;
		store_req.addr       = idx_q;
		store_req.req_wdata  = item.required_count;
		store_req.flag_wdata = alu_result;
		alu_op               = ALU_PASS;
		alu_word             = flag_rdata;
		unique case (state_q)
			S_IDLE: begin
				store_req.addr   = idx_t'(count_q);
				store_req.req_we = accept && (item.kind == KIND_DEFINE) &&
				                   !def_full && !def_too_many;
			end
			S_BEGIN_WR: begin
				alu_op            = ALU_ARM;
				store_req.flag_we = 1'b1;
			end
			S_EVT_WR: begin
				if (is_reject_q) begin
					alu_op = ALU_SET_REJECT;
				end else if (expr_q != '0) begin
					alu_op = ALU_CLEAR_BIT;
				end
				store_req.flag_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	semc_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (store_req),
		.req_rdata  (req_rdata),
		.flag_rdata (flag_rdata)
	);

	semc_flag_alu u_alu (
		.op      (alu_op),
		.word    (alu_word),
		.count   (req_rdata),
		.bit_sel (expr_q),
		.result  (alu_result),
		.zero    (alu_zero)
	);

	// Sequencer, item registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			idx_q         <= '0;
			is_reject_q   <= 1'b0;
			expr_q        <= '0;
			emit_status_q <= ST_NONE;
			emit_index_q  <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= ST_NONE;
			out_index_q   <= '0;
		end else begin
			// Load the output register from the emit stage, or drop it once
			// its transfer has gone.
			if ((state_q == S_EMIT) && out_free) begin
				out_valid_q  <= 1'b1;
				out_status_q <= emit_status_q;
				out_index_q  <= emit_index_q;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q       <= (item.kind == KIND_EVENT) ? idx_t'(snum_m1) : '0;
						is_reject_q <= item.is_reject;
						expr_q      <= item.expression_number;
						unique case (item.kind)
							KIND_DEFINE: begin
								state_q <= S_EMIT;
								if (def_full) begin
									emit_status_q <= ST_FULL;
									emit_index_q  <= '0;
								end else if (def_too_many) begin
									emit_status_q <= ST_TOO_MANY;
									emit_index_q  <= '0;
								end else begin
									emit_status_q <= ST_DEFINED;
									emit_index_q  <= snum_t'(count_q);
									count_q       <= count_q + cnt_t'(1);
								end
							end
							KIND_BEGIN: begin
								if (count_q != '0) begin
									state_q <= S_BEGIN_RD;
								end
							end
							KIND_EVENT: begin
								if (!evt_ignored) begin
									state_q <= S_EVT_RD;
								end
							end
							default: begin
								if (count_q != '0) begin
									state_q <= S_DEC_RD;
								end else begin
									emit_status_q <= ST_NONE;
									emit_index_q  <= '0;
									state_q       <= S_EMIT;
								end
							end
						endcase
					end
				end
				S_BEGIN_RD: state_q <= S_BEGIN_WR;
				S_BEGIN_WR: begin
					if (idx_last) begin
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_t'(idx_next);
						state_q <= S_BEGIN_RD;
					end
				end
				S_EVT_RD: state_q <= S_EVT_WR;
				S_EVT_WR: state_q <= S_IDLE;
				S_DEC_RD: state_q <= S_DEC_CHK;
				S_DEC_CHK: begin
					if (alu_zero) begin
						emit_status_q <= ST_FOUND;
						emit_index_q  <= snum_t'(idx_q);
						state_q       <= S_EMIT;
					end else if (idx_last) begin
						emit_status_q <= ST_NONE;
						emit_index_q  <= '0;
						state_q       <= S_EMIT;
					end else begin
						idx_q   <= idx_t'(idx_next);
						state_q <= S_DEC_RD;
					end
				end
				S_EMIT: begin
					// Hold until the output register is free.
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item.ready          = (state_q == S_IDLE);
	assign result.valid        = out_valid_q;
	assign result.status       = out_status_q;
	assign result.schema_index = out_index_q;

	`SEMC_ASSERT_NOW(a_found_in_table, out_valid_q && (out_status_q == ST_FOUND), snum_t'(out_index_q) < snum_t'(count_q), "found schema beyond defined count")
	`SEMC_ASSERT_NOW(a_count_bound, 1'b1, count_q <= cnt_t'(SCHEMA_SLOTS), "schema count above slot count")
	`SEMC_ASSERT_NEXT(a_begin_walks, accept && (item.kind == KIND_BEGIN) && (count_q != '0), state_q == S_BEGIN_RD, "begin did not start arming walk")
	`SEMC_ASSERT_NEXT(a_emit_holds, (state_q == S_EMIT) && out_valid_q && !result.ready, state_q == S_EMIT, "result overwrote a waiting transfer")

endmodule
